// File: rtl/u8l1_pkg.sv
// ----------------------------------------------------------------------------
// u8l1_pkg
// Shared types, codes and helpers of the UTF-8 to Latin-1 escaping decoder.
// ----------------------------------------------------------------------------
package u8l1_pkg;

    // Longest UTF-8 sequence that is buffered, and default queue depth.
    localparam int C_SEQ_DEPTH   = 6;
    localparam int C_QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [0:0] CFG_QUOTE_DELIM = 1'b0;
    localparam logic [0:0] CFG_OUTPUT_MODE = 1'b1;

    // Command kinds handed from the front to the back.
    localparam logic [1:0] K_RAW   = 2'd0;  // copy data bytes as they are
    localparam logic [1:0] K_SHORT = 2'd1;  // backslash, then data byte 0
    localparam logic [1:0] K_HEX   = 2'd2;  // backslash-x-hex-hex per data byte

    // Characters used by the quoting and escaping logic.
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] DELIM_OFF = 8'hff;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic signed [7:0] quote_delim;
        logic              output_mode;
    } t_cfg;

    // One command covers every output byte that a single input item causes.
    typedef struct packed {
        logic [1:0]                  kind;
        logic [2:0]                  cnt;
        logic [C_SEQ_DEPTH-1:0][7:0] data;
    } t_cmd;

    // Lowercase ASCII hex digit of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h57 + wide);
    endfunction

endpackage

// File: rtl/utf8_to_latin1_escaping_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_latin1_escaping_decoder
// UTF-8 to Latin-1 converting decoder with backslash escaping and quoting.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_stall    i_item (in_byte, end_of_string)
//   output    out        o_valid / i_stall    o_item (out_byte, last_of_run)
//   config    in         i_cfg_we             i_cfg_index, i_cfg_wdata
//
// The front takes one input item per cycle while the command queue has room.
// The back end sends one output byte per cycle unless the output stalls: each
// hex escape is four bytes, and a broken six-byte sequence up to 24 bytes.
// Reset is synchronous and active low; there is no clearing pass.
// The queue and the output register let input and output stall separately.
// ----------------------------------------------------------------------------
module utf8_to_latin1_escaping_decoder
    import u8l1_pkg::*;
#(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_item,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata
);

    t_cfg r_cfg;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_head_valid;
    t_cmd q_cmd;
    t_cmd q_head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quote_delim <= DELIM_OFF;
            r_cfg.output_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUOTE_DELIM: r_cfg.quote_delim <= i_cfg_wdata;
                CFG_OUTPUT_MODE: r_cfg.output_mode <= i_cfg_wdata[0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // Decode and classify.
    u8l1_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_cmd)
    );

    // Command queue.
    u8l1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_cmd        (q_cmd),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // Output expansion.
    u8l1_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_item       (o_item)
    );

endmodule

// File: rtl/u8l1_front.sv
// ----------------------------------------------------------------------------
// u8l1_front
// Accepts input bytes, tracks the UTF-8 decoder state and turns each item
// into at most one output command for the back end.
// ----------------------------------------------------------------------------
module u8l1_front
    import u8l1_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    // Decoder state. The character value is kept as its low byte plus a
    // sticky flag for any higher bit, which is all the range check needs.
    logic [2:0] r_bytes_pending, n_bytes_pending;
    logic [2:0] r_seq_count,     n_seq_count;
    logic [7:0] r_char_low,      n_char_low;
    logic       r_char_high,     n_char_high;
    logic       r_resync,        n_resync;
    logic [7:0] r_seq_bytes [C_SEQ_DEPTH];

    logic       accept;
    logic [7:0] b;
    logic [7:0] delim_u;
    logic       quote_on;
    logic       needs_quote;
    logic       resync_ok;
    logic       is_cont;
    logic [2:0] slot;
    logic       seq_we;
    logic [2:0] seq_idx;
    logic [7:0] cont_low;
    logic       cont_high;
    logic [2:0] cnt_plus;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;
    assign b       = i_item.in_byte;
    assign delim_u = i_cfg.quote_delim;

    // Classification of the incoming byte.
    assign quote_on    = (delim_u != DELIM_OFF);
    assign needs_quote = quote_on && ((b < CH_SPACE) || (b == CH_DEL) || (b == delim_u) ||
                                      ((delim_u != 8'h00) && (b == CH_BSLASH)));
    assign resync_ok   = !b[7] || ((b >= 8'hc0) && (b <= 8'hfd));
    assign is_cont     = (b[7:6] == 2'b10);
    assign slot        = (r_bytes_pending == 3'd0) ? 3'd0 : r_seq_count;
    assign cont_low    = {r_char_low[1:0], b[5:0]};
    assign cont_high   = r_char_high || (r_char_low[7:2] != 6'd0);
    assign cnt_plus    = r_seq_count + 3'd1;

    // Next state and command for the accepted byte.
    always_comb begin
        n_bytes_pending = r_bytes_pending;
        n_seq_count     = r_seq_count;
        n_char_low      = r_char_low;
        n_char_high     = r_char_high;
        n_resync        = r_resync;
        seq_we          = 1'b0;
        seq_idx         = r_seq_count;
        o_push          = 1'b0;
        o_cmd.kind      = K_HEX;
        o_cmd.cnt       = 3'd1;
        for (int i = 0; i < C_SEQ_DEPTH; i++) begin
            o_cmd.data[i] = (3'(i) < slot) ? r_seq_bytes[i] : b;
        end

        if (accept) begin
            if (r_resync && !resync_ok) begin
                o_push = 1'b1;
            end else begin
                n_resync = 1'b0;
                if (r_bytes_pending == 3'd0) begin
                    seq_idx = 3'd0;
                    if (!b[7]) begin
                        o_push = 1'b1;
                        if (needs_quote) begin
                            o_cmd.kind = K_SHORT;
                            case (b)
                                8'h0a: o_cmd.data[0] = 8'h6e;
                                8'h0d: o_cmd.data[0] = 8'h72;
                                8'h0c: o_cmd.data[0] = 8'h66;
                                8'h0b: o_cmd.data[0] = 8'h76;
                                8'h08: o_cmd.data[0] = 8'h62;
                                8'h00: o_cmd.data[0] = 8'h30;
                                default: o_cmd.kind = K_HEX;
                            endcase
                        end else begin
                            o_cmd.kind = K_RAW;
                        end
                    end else if (b[7:5] == 3'b110) begin
                        seq_we = 1'b1; n_bytes_pending = 3'd1; n_char_low = b & 8'h1f;
                    end else if (b[7:4] == 4'b1110) begin
                        seq_we = 1'b1; n_bytes_pending = 3'd2; n_char_low = b & 8'h0f;
                    end else if (b[7:3] == 5'b11110) begin
                        seq_we = 1'b1; n_bytes_pending = 3'd3; n_char_low = b & 8'h07;
                    end else if (b[7:2] == 6'b111110) begin
                        seq_we = 1'b1; n_bytes_pending = 3'd4; n_char_low = b & 8'h03;
                    end else if (b[7:1] == 7'b1111110) begin
                        seq_we = 1'b1; n_bytes_pending = 3'd5; n_char_low = b & 8'h01;
                    end else begin
                        o_push   = 1'b1;
                        n_resync = 1'b1;
                    end
                    if (seq_we) begin
                        n_char_high = 1'b0;
                        n_seq_count = 3'd1;
                    end
                end else if (!is_cont) begin
                    // Broken sequence: escape the buffered bytes and this one.
                    o_push          = 1'b1;
                    o_cmd.cnt       = cnt_plus;
                    n_bytes_pending = 3'd0;
                    n_seq_count     = 3'd0;
                    n_resync        = 1'b1;
                end else begin
                    seq_we          = 1'b1;
                    n_char_low      = cont_low;
                    n_char_high     = cont_high;
                    n_bytes_pending = r_bytes_pending - 3'd1;
                    n_seq_count     = cnt_plus;
                    if (r_bytes_pending == 3'd1) begin
                        // Sequence complete.
                        o_push      = 1'b1;
                        o_cmd.cnt   = cnt_plus;
                        n_seq_count = 3'd0;
                        if (i_cfg.output_mode) begin
                            o_cmd.kind = K_RAW;
                        end else if (!cont_high && cont_low[7]) begin
                            o_cmd.kind    = K_RAW;
                            o_cmd.cnt     = 3'd1;
                            o_cmd.data[0] = cont_low;
                        end
                    end
                end
            end

            if (i_item.end_of_string) begin
                n_bytes_pending = 3'd0;
                n_seq_count     = 3'd0;
                n_char_low      = 8'h00;
                n_char_high     = 1'b0;
                n_resync        = 1'b0;
            end
        end
    end

    // Decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_pending <= 3'd0;
            r_seq_count     <= 3'd0;
            r_char_low      <= 8'h00;
            r_char_high     <= 1'b0;
            r_resync        <= 1'b0;
        end else begin
            r_bytes_pending <= n_bytes_pending;
            r_seq_count     <= n_seq_count;
            r_char_low      <= n_char_low;
            r_char_high     <= n_char_high;
            r_resync        <= n_resync;
        end
    end

    // Sequence byte buffer; only entries below the count are ever read.
    always_ff @(posedge i_clk) begin
        if (seq_we) begin
            r_seq_bytes[seq_idx] <= b;
        end
    end

    // Resync is only ever raised with no sequence in progress.
    a_resync_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resync |-> (r_bytes_pending == 3'd0))
        else $error("resync set while a sequence is pending");

    // A pending sequence always holds its lead byte.
    a_pending_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_pending != 3'd0) |-> (r_seq_count != 3'd0))
        else $error("pending sequence without buffered bytes");

    // Buffered plus still expected bytes never exceed the longest sequence.
    a_seq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_seq_count} + {1'b0, r_bytes_pending}) <= 4'(C_SEQ_DEPTH))
        else $error("sequence length out of range");

endmodule

// File: rtl/u8l1_queue.sv
// ----------------------------------------------------------------------------
// u8l1_queue
// Small command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module u8l1_queue
    import u8l1_pkg::*;
#(
    parameter int DEPTH = C_QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // No push into a full queue and no pop from an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("queue underflow");

    // The fill count follows pushes and pops exactly.
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_push) && !$past(i_pop)) |->
            (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

// File: rtl/u8l1_back.sv
// ----------------------------------------------------------------------------
// u8l1_back
// Expands the command at the queue head into output bytes, one per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module u8l1_back
    import u8l1_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_cmd      i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic [2:0] r_idx, n_idx;     // data byte within the command
    logic [1:0] r_ph,  n_ph;      // character within one escape
    logic       r_valid;
    t_out_item  r_out;

    logic       load;
    logic [7:0] cur;
    logic [7:0] byte_sel;
    logic       byte_done;
    logic       cmd_last;

    assign load    = i_head_valid && (!r_valid || !i_stall);
    assign cur     = i_head.data[r_idx];
    assign o_valid = r_valid;
    assign o_item  = r_out;

    // Pick the next output character of the current command.
    always_comb begin
        byte_sel  = cur;
        byte_done = 1'b1;
        case (i_head.kind)
            K_SHORT: begin
                byte_sel  = (r_ph == 2'd0) ? CH_BSLASH : cur;
                byte_done = (r_ph == 2'd1);
            end
            K_HEX: begin
                case (r_ph)
                    2'd0:    byte_sel = CH_BSLASH;
                    2'd1:    byte_sel = CH_X;
                    2'd2:    byte_sel = hex_char(cur[7:4]);
                    default: byte_sel = hex_char(cur[3:0]);
                endcase
                byte_done = (r_ph == 2'd3);
            end
            default: begin
                byte_sel  = cur;
                byte_done = 1'b1;
            end
        endcase
        cmd_last = byte_done && (r_idx == i_head.cnt - 3'd1);
    end

    // Position counters within the command.
    always_comb begin
        n_idx = r_idx;
        n_ph  = r_ph;
        o_pop = 1'b0;
        if (load) begin
            if (cmd_last) begin
                n_idx = 3'd0;
                n_ph  = 2'd0;
                o_pop = 1'b1;
            end else if (byte_done) begin
                n_idx = r_idx + 3'd1;
                n_ph  = 2'd0;
            end else begin
                n_ph  = r_ph + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_ph    <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_ph  <= n_ph;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte    <= byte_sel;
            r_out.last_of_run <= cmd_last;
        end
    end

    // The byte index stays inside the command's data.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_idx < i_head.cnt))
        else $error("byte index beyond command length");

    // A command that is partly sent stays at the queue head.
    a_mid_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_ph != 2'd0) || (r_idx != 3'd0)) |-> i_head_valid)
        else $error("command left the queue while partly sent");

    // A short escape only ever uses its first data byte.
    a_short_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head_valid && (i_head.kind == K_SHORT)) |-> (r_idx == 3'd0))
        else $error("short escape beyond its first byte");

endmodule
